FILE: src/jhs_pkg.sv
// ----------------------------------------------------------------------------
// jhs_pkg
// Shared constants and types for the Jacobi heat stencil sweep unit.
// ----------------------------------------------------------------------------
package jhs_pkg;

  // Configuration register file.
  localparam int unsigned CFG_DATA_BITS   = 32;
  localparam int unsigned CFG_ADDR_BITS   = 3;
  localparam logic        CFG_IDX_GRID_WIDTH = 1'b0;   // word index, paddr[2]

  localparam int unsigned GRID_WIDTH_BITS  = 11;
  localparam int unsigned GRID_WIDTH_RESET = 3;
  localparam int unsigned GRID_WIDTH_MIN   = 3;

  // Control half of a result travelling from the sweep core to the output stage.
  typedef struct packed {
    logic valid;
    logic last;
  } jhs_res_ctl_t;

endpackage

FILE: src/jhs_line_buf.sv
// ----------------------------------------------------------------------------
// jhs_line_buf
// One-row line buffer: single write port, single registered read port.
// ----------------------------------------------------------------------------
module jhs_line_buf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DATA_BITS = 24,
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/jhs_sweep_core.sv
// ----------------------------------------------------------------------------
// jhs_sweep_core
// Raster position counters, neighbor window, line buffers and the
// five-point average. One accepted item advances the window by one column.
// ----------------------------------------------------------------------------
module jhs_sweep_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned VALUE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        eff_w,
  input  logic [$clog2(MAX_WIDTH)-1:0]          last_col,
  input  logic                                  accept,
  input  logic [VALUE_BITS-1:0]                 cell_value,
  input  logic                                  flush,
  output logic [VALUE_BITS-1:0]                 res_value,
  output jhs_pkg::jhs_res_ctl_t                 res_ctl
);

  import jhs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = VALUE_BITS + 2;

  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [VALUE_BITS-1:0] win_cur_r;   // current row buffer at this column
  logic [VALUE_BITS-1:0] left_r;      // row above output, one column left
  logic [VALUE_BITS-1:0] rd_cur;      // current row buffer, next column
  logic [VALUE_BITS-1:0] rd_abv;      // upper row buffer, this column

  logic          draining, at_last_col, advance, border;
  logic [RW:0]   col_p2;
  logic [CW-1:0] cur_rd_addr;
  logic [SW-1:0] sum;

  assign draining    = (row_r == eff_w);
  assign at_last_col = (col_r == last_col);
  assign advance     = accept && (draining || !flush);

  // Prefetch addresses: the current row buffer runs two columns ahead,
  // the upper row buffer one column ahead, both wrapping at the row end.
  always_comb begin
    col_p2 = (RW+1)'(col_r) + (RW+1)'(2);
    if (col_p2 >= {1'b0, eff_w}) begin
      col_p2 = col_p2 - {1'b0, eff_w};
    end
    cur_rd_addr = col_p2[CW-1:0];
  end

  assign col_nxt = at_last_col ? '0 : col_r + CW'(1);

  always_comb begin
    row_nxt = row_r;
    if (at_last_col) begin
      row_nxt = draining ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_cur_r <= rd_cur;
      left_r    <= win_cur_r;
    end
  end

  jhs_line_buf #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (VALUE_BITS),
    .ADDR_BITS (CW)
  ) u_cur_buf (
    .clk     (clk),
    .wr_en   (advance && !draining),
    .wr_addr (col_r),
    .wr_data (cell_value),
    .rd_en   (advance),
    .rd_addr (cur_rd_addr),
    .rd_data (rd_cur)
  );

  jhs_line_buf #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (VALUE_BITS),
    .ADDR_BITS (CW)
  ) u_abv_buf (
    .clk     (clk),
    .wr_en   (advance && !draining),
    .wr_addr (col_r),
    .wr_data (win_cur_r),
    .rd_en   (advance),
    .rd_addr (col_nxt),
    .rd_data (rd_abv)
  );

  assign sum = SW'(rd_abv) + SW'(left_r) + SW'(rd_cur) + SW'(cell_value);
  assign border = draining || (row_r == RW'(1)) || (col_r == '0) || at_last_col;

  always_comb begin
    res_value     = border ? win_cur_r : sum[SW-1:2];
    res_ctl.valid = accept && (draining || (!flush && (row_r != '0)));
    res_ctl.last  = draining && at_last_col;
  end

  ap_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= last_col) else $error("column counter beyond row end");

  ap_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= eff_w) else $error("row counter beyond drain row");

  ap_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (col_r == '0) && (row_r == '0))
    else $error("grid restart did not clear position");

endmodule

FILE: src/jhs_out_skid.sv
// ----------------------------------------------------------------------------
// jhs_out_skid
// Two-entry output stage: result register plus skid register, so the
// upstream ready is a register and never waits on the downstream ready.
// ----------------------------------------------------------------------------
module jhs_out_skid #(
  parameter int unsigned VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jhs_pkg::jhs_res_ctl_t push_ctl,
  input  logic [VALUE_BITS-1:0] push_value,
  output logic                  push_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic                  out_last
);

  import jhs_pkg::*;

  logic                  out_v_r, skid_v_r;
  logic                  out_last_r, skid_last_r;
  logic [VALUE_BITS-1:0] out_value_r, skid_value_r;
  logic                  out_fire;

  assign out_fire   = out_v_r && out_ready;
  assign push_ready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_fire) begin
      skid_v_r <= push_ctl.valid;
    end else begin
      out_v_r <= push_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_value_r <= skid_value_r;
        out_last_r  <= skid_last_r;
      end
    end else if (out_v_r && !out_fire) begin
      skid_value_r <= push_value;
      skid_last_r  <= push_ctl.last;
    end else begin
      out_value_r <= push_value;
      out_last_r  <= push_ctl.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  ap_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry without output entry");

  ap_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_ctl.valid |-> !skid_v_r) else $error("result pushed into full stage");

  ap_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_ready |=> !skid_v_r && out_v_r)
    else $error("skid entry not moved forward");

endmodule

FILE: src/jacobi_heat_stencil_sweep_unit.sv
// ----------------------------------------------------------------------------
// jacobi_heat_stencil_sweep_unit
// One Jacobi five-point sweep over a square grid streamed in raster order.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  Payload                                  Handshake
//  in_*        in   tdata = cell_value, tuser = flush        tvalid/tready
//  out_*       out  tdata = new_value, tlast = last          tvalid/tready
//  cfg_*       in   APB, grid_width at byte address 0        psel/penable/pready
//
// The unit takes one beat per clock while in_tready is high; the rate is set by the two
// simple dual-port line buffers, each of which is written once and read once per beat;
// the reads fetch the neighbors for the following column ahead of time.
// Each result is registered in the output stage before it leaves, and the
// stream as a whole runs one grid row behind the input. Flush beats (or any
// beat once the last row is in) drain the bottom row, which ends with tlast.
// Reset is synchronous and active low. It clears the position counters, the
// output stage and grid_width (to 3); the line buffers are not cleared and
// there is no clearing pass, because a grid always writes a row before it
// reads it. A stall on out_tready fills the skid register, which drops
// in_tready; in_tready is a register output.
//
// Interior cells become (up + down + left + right) >> 2 in 8.16 unsigned
// fixed point, truncated. Border cells pass through unchanged. Writing
// grid_width clamps the effective width to [3, MAX_WIDTH] and starts a new grid.
// ----------------------------------------------------------------------------
module jacobi_heat_stencil_sweep_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned VALUE_BITS = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,

  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]         in_tdata,   // cell_value
  input  logic                                    in_tuser,   // flush

  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]         out_tdata,  // new_value
  output logic                                    out_tlast,  // last

  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [jhs_pkg::CFG_ADDR_BITS-1:0]       cfg_paddr,
  input  logic [jhs_pkg::CFG_DATA_BITS-1:0]       cfg_pwdata,
  output logic [jhs_pkg::CFG_DATA_BITS-1:0]       cfg_prdata,
  output logic                                    cfg_pready
);

  import jhs_pkg::*;

  localparam int unsigned TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (RW > GRID_WIDTH_BITS) ? RW : GRID_WIDTH_BITS;

  logic [GRID_WIDTH_BITS-1:0] grid_width_r;
  logic [RW-1:0]              eff_w_r;
  logic [CW-1:0]              last_col_r;
  logic [CMPW-1:0]            wr_width, eff_w_nxt;
  logic                       cfg_wr_grid;

  logic                       accept;
  logic                       push_ready;
  logic [VALUE_BITS-1:0]      res_value, out_value;
  jhs_res_ctl_t               res_ctl;

  // ---- Configuration port -------------------------------------------------
  assign cfg_pready  = 1'b1;
  assign cfg_wr_grid = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       (cfg_paddr[2] == CFG_IDX_GRID_WIDTH);

  // The clamped width and the last column index are registered at the write,
  // so the stream path only sees plain compares against them.
  always_comb begin
    wr_width = CMPW'(cfg_pwdata[GRID_WIDTH_BITS-1:0]);
    if (wr_width < CMPW'(GRID_WIDTH_MIN)) begin
      eff_w_nxt = CMPW'(GRID_WIDTH_MIN);
    end else if (wr_width > CMPW'(MAX_WIDTH)) begin
      eff_w_nxt = CMPW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = wr_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_WIDTH_BITS'(GRID_WIDTH_RESET);
      eff_w_r      <= RW'(GRID_WIDTH_RESET);
      last_col_r   <= CW'(GRID_WIDTH_RESET - 1);
    end else if (cfg_wr_grid) begin
      grid_width_r <= cfg_pwdata[GRID_WIDTH_BITS-1:0];
      eff_w_r      <= RW'(eff_w_nxt);
      last_col_r   <= CW'(eff_w_nxt - CMPW'(1));
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_GRID_WIDTH) ?
                      CFG_DATA_BITS'(grid_width_r) : '0;

  // ---- Stream path ----------------------------------------------------------
  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;

  jhs_sweep_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr_grid),
    .eff_w      (eff_w_r),
    .last_col   (last_col_r),
    .accept     (accept),
    .cell_value (in_tdata[VALUE_BITS-1:0]),
    .flush      (in_tuser),
    .res_value  (res_value),
    .res_ctl    (res_ctl)
  );

  jhs_out_skid #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_ctl   (res_ctl),
    .push_value (res_value),
    .push_ready (push_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDATA_BITS'(out_value);

endmodule
